/* rtl/core/repeating_fraction_cycle_extractor_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the repeating fraction cycle extractor
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REPEATING_FRACTION_CYCLE_EXTRACTOR_UNIT_MACROS_SVH
`define REPEATING_FRACTION_CYCLE_EXTRACTOR_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define RFCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define RFCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rfce_pkg.sv */
// ----------------------------------------------------------------------------
// rfce_pkg
// Types and fixed widths shared by the cycle extractor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfce_pkg;

    localparam int NUM_W   = 16;
    localparam int DEN_W   = 7;
    localparam int RADIX_W = 8;
    localparam int PROD_W  = DEN_W + RADIX_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [NUM_W-1:0]   numerator;
        logic [DEN_W-1:0]   denominator;
        logic [RADIX_W-1:0] radix;
    } in_item_t;

    typedef struct packed {
        logic [RADIX_W-1:0] digit;
        logic               last;
        logic               no_digits;
        logic               terminates;
    } result_t;

    // Classification made by the front end
    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,   // zero or out of range denominator
        KIND_ZERO  = 2'd1,   // starting remainder is zero
        KIND_RUN   = 2'd2    // long division needed
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [DEN_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [RADIX_W-1:0] radix;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

endpackage

/* rtl/core/rfce_front.sv */
// ----------------------------------------------------------------------------
// rfce_front
// Accepts an item, reduces the numerator modulo the denominator bit-serially
// and classifies the job before queueing it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfce_front
    import rfce_pkg::*;
#(
    parameter int MAX_DENOMINATOR = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    input  q_status_t qstat,
    output job_push_t push
);

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MOD  = 3'b010,
        F_PUSH = 3'b100
    } f_state_t;

    f_state_t            state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DEN_W-1:0]    part_reg, part_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;

    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      trial_sub;
    logic                trial_ge;
    logic                den_bad;
    job_kind_t           kind;

    // one restoring step: bring in the next numerator bit
    assign trial     = {part_reg, num_reg[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    assign den_bad = (den_reg == '0)
                  || ({{(32-DEN_W){1'b0}}, den_reg} > 32'(MAX_DENOMINATOR));

    always_comb
    begin
        if (den_bad)
        begin
            kind = KIND_EMPTY;
        end
        else if (part_reg == '0)
        begin
            kind = KIND_ZERO;
        end
        else
        begin
            kind = KIND_RUN;
        end
    end

    assign busy            = (state_reg != F_IDLE);
    assign push.valid      = (state_reg == F_PUSH) && !qstat.full;
    assign push.job.kind   = kind;
    assign push.job.rem    = part_reg;
    assign push.job.den    = den_reg;
    assign push.job.radix  = radix_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        num_next   = num_reg;
        part_next  = part_reg;
        den_next   = den_reg;
        radix_next = radix_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    num_next   = item.numerator;
                    den_next   = item.denominator;
                    radix_next = item.radix;
                    part_next  = '0;
                    step_next  = '0;
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                part_next = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!qstat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        num_reg   <= num_next;
        part_reg  <= part_next;
        den_reg   <= den_next;
        radix_reg <= radix_next;
    end

endmodule

/* rtl/core/rfce_queue.sv */
// ----------------------------------------------------------------------------
// rfce_queue
// Short job queue between the front end and the division engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfce_queue
    import rfce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_push_t push,
    input  logic      pop,
    output job_t      head,
    output q_status_t qstat
);

    job_t               entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;

    assign head           = entries[rd_ptr_reg];
    assign qstat.full     = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.nonempty = (fill_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push.valid && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push.valid)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries[wr_ptr_reg] <= push.job;
        end
    end

endmodule

/* rtl/core/rfce_back.sv */
// ----------------------------------------------------------------------------
// rfce_back
// Long division engine: remainder history lookup, multiply, 8-step
// division, then replay of the stored digits as results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfce_back
    import rfce_pkg::*;
#(
    parameter int MAX_DENOMINATOR = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  q_status_t qstat,
    output logic      pop,
    output logic      result_strobe,
    output result_t   result
);

    localparam int ADDR_W = $clog2(MAX_DENOMINATOR);
    localparam int STEP_W = $clog2(RADIX_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RADIX_W - 1);

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_LOOK   = 6'b000010,
        B_CHECK  = 6'b000100,
        B_DECIDE = 6'b001000,
        B_DIV    = 6'b010000,
        B_EMIT   = 6'b100000
    } b_state_t;

    // seen_pos[r]: position where remainder r appeared; rem_store[p]: remainder
    // at position p. A hit needs both to agree, so no clearing is needed.
    logic [ADDR_W-1:0]  seen_pos    [MAX_DENOMINATOR];
    logic [DEN_W-1:0]   rem_store   [MAX_DENOMINATOR];
    logic [RADIX_W-1:0] digit_store [MAX_DENOMINATOR];

    logic [ADDR_W-1:0]  pos_rd;
    logic [DEN_W-1:0]   rem_rd;
    logic [RADIX_W-1:0] digit_rd;

    b_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]  emit_idx_reg, emit_idx_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               term_item_reg, term_item_next;
    logic               strobe_reg, strobe_next;
    logic               out_last_reg, out_last_next;
    logic               out_nod_reg, out_nod_next;
    logic               out_term_reg, out_term_next;
    logic               out_mem_reg, out_mem_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [PROD_W-1:0]  div_reg, div_next;

    logic               pos_we, pos_re, rem_re, dig_we, dig_re;
    logic [ADDR_W-1:0]  rem_addr;
    logic [ADDR_W-1:0]  idx_inc;
    logic [PROD_W-1:0]  prod;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     trial_sub;
    logic               trial_ge;
    logic [PROD_W-1:0]  div_step;

    assign rem_addr = ADDR_W'(rem_reg);
    assign idx_inc  = emit_idx_reg + 1'b1;
    assign prod     = {{RADIX_W{1'b0}}, rem_reg} * {{DEN_W{1'b0}}, radix_reg};

    // div_reg = {partial remainder, dividend bits / quotient bits}
    assign trial     = {div_reg[PROD_W-1:RADIX_W], div_reg[RADIX_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign div_step  = {(trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0]),
                        div_reg[RADIX_W-2:0], trial_ge};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        step_next      = step_reg;
        term_item_next = term_item_reg;
        strobe_next    = 1'b0;
        out_last_next  = out_last_reg;
        out_nod_next   = out_nod_reg;
        out_term_next  = out_term_reg;
        out_mem_next   = out_mem_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        radix_next     = radix_reg;
        div_next       = div_reg;
        pop            = 1'b0;
        pos_we         = 1'b0;
        pos_re         = 1'b0;
        rem_re         = 1'b0;
        dig_we         = 1'b0;
        dig_re         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (qstat.nonempty)
                begin
                    pop        = 1'b1;
                    rem_next   = head.rem;
                    den_next   = head.den;
                    radix_next = head.radix;
                    count_next = '0;
                    if (head.kind == KIND_RUN)
                    begin
                        state_next = B_LOOK;
                    end
                    else
                    begin
                        strobe_next   = 1'b1;
                        out_last_next = 1'b1;
                        out_nod_next  = 1'b1;
                        out_mem_next  = 1'b0;
                        out_term_next = (head.kind == KIND_ZERO);
                    end
                end
            end
            B_LOOK:
            begin
                pos_re     = 1'b1;
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                rem_re     = 1'b1;
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                if ((pos_rd < count_reg) && (rem_rd == rem_reg))
                begin
                    // remainder seen before: emit the cycle from its position
                    emit_idx_next  = pos_rd;
                    term_item_next = 1'b0;
                    state_next     = B_EMIT;
                end
                else
                begin
                    pos_we     = 1'b1;
                    div_next   = prod;
                    step_next  = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                div_next  = div_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    dig_we     = 1'b1;
                    rem_next   = div_step[PROD_W-1:RADIX_W];
                    count_next = count_reg + 1'b1;
                    if (div_step[PROD_W-1:RADIX_W] == '0)
                    begin
                        term_item_next = 1'b1;
                        emit_idx_next  = '0;
                        state_next     = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_LOOK;
                    end
                end
            end
            B_EMIT:
            begin
                dig_re        = 1'b1;
                strobe_next   = 1'b1;
                out_mem_next  = 1'b1;
                out_nod_next  = 1'b0;
                out_term_next = term_item_reg;
                out_last_next = (idx_inc == count_reg);
                emit_idx_next = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_idx_reg  <= emit_idx_next;
        step_reg      <= step_next;
        term_item_reg <= term_item_next;
        out_last_reg  <= out_last_next;
        out_nod_reg   <= out_nod_next;
        out_term_reg  <= out_term_next;
        out_mem_reg   <= out_mem_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        radix_reg     <= radix_next;
        div_reg       <= div_next;
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            seen_pos[rem_addr]   <= count_reg;
            rem_store[count_reg] <= rem_reg;
        end
        if (dig_we)
        begin
            digit_store[count_reg] <= div_step[RADIX_W-1:0];
        end
        if (pos_re)
        begin
            pos_rd <= seen_pos[rem_addr];
        end
        if (rem_re)
        begin
            rem_rd <= rem_store[pos_rd];
        end
        if (dig_re)
        begin
            digit_rd <= digit_store[emit_idx_reg];
        end
    end

    assign result_strobe     = strobe_reg;
    assign result.digit      = out_mem_reg ? digit_rd : '0;
    assign result.last       = out_last_reg;
    assign result.no_digits  = out_nod_reg;
    assign result.terminates = out_term_reg;

endmodule

/* rtl/core/repeating_fraction_cycle_extractor_unit.sv */
// ----------------------------------------------------------------------------
// repeating_fraction_cycle_extractor_unit - repeating fraction cycle extractor
// Each digit costs a history lookup (LOOK, CHECK, DECIDE) and 8 division
// steps in the engine. The front end takes no new item until it has queued
// the last one; a 2-entry queue lets it run ahead of the engine.
// Reset: async, rst_n low. Results never stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "repeating_fraction_cycle_extractor_unit_macros.svh"

module repeating_fraction_cycle_extractor_unit
    import rfce_pkg::*;
#(
    parameter int MAX_DENOMINATOR = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  in_item_t item,
    output logic     result_strobe,
    output result_t  result
);

    // Transfer in: start high while busy low. The front end holds busy for
    // the whole modulo reduction and while the queue has no room.
    // Transfer out: result_strobe marks each result for one cycle; the
    // receiver must take it. Digits of one item come out back to back.
    //
    // Engine history: the remainder table and position table are never
    // cleared. A remainder counts as seen only when its recorded position is
    // below the current digit count and that position maps back to it.

    job_push_t push;
    job_t      head;
    q_status_t qstat;
    logic      pop;
    logic      empty_out;

    rfce_front #(
        .MAX_DENOMINATOR (MAX_DENOMINATOR)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .qstat (qstat),
        .push  (push)
    );

    rfce_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    rfce_back #(
        .MAX_DENOMINATOR (MAX_DENOMINATOR)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .qstat         (qstat),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // strobed result that carries no digit
    assign empty_out = result_strobe && result.no_digits;

    // accepted item keeps the front end occupied for the reduction
    `RFCE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "front end free after accept")
    // empty results are always single and carry digit zero
    `RFCE_ASSERT_NOW(a_empty_last, empty_out, result.last, "empty result not last")
    `RFCE_ASSERT_NOW(a_empty_digit, empty_out, result.digit == '0, "empty result has digit")
    // the front end never pushes into a full queue
    `RFCE_ASSERT_NOW(a_push_room, push.valid, !qstat.full, "push into full queue")

endmodule
